// ===== src/pds_pkg.sv =====
// Shared types and constants of the path dot-segment simplifier.
// No dependencies; used by the top level, the checker and the testbench.

package pds_pkg;

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_DOT    = 2'd1,
        CLS_DOTDOT = 2'd2,
        CLS_NAME   = 2'd3
    } t_seg_class;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

endpackage

// ===== src/path_dot_segment_simplifier.sv =====
// Top level of the path dot-segment simplifier: control sequencer around two RAMs.
// Depends on pds_pkg and pds_ram.
//
// Usage:
//   Request channel: i_path_byte / i_path_end with i_path_valid / o_path_ready.
//   One request per path character; i_path_end marks the last one.
//   Result channel: o_result_byte / o_result_end / o_overflow with
//   o_result_valid / i_result_ready; o_result_end marks the last character.
// Sequencing:
//   A plain name byte is written in S_IDLE, the first byte of a segment
//   also in S_OPEN2 (the '/' and the byte go through the single write port
//   of the byte store; not when there is no room and the byte is dropped),
//   a '/' closes the segment in S_CLOSE and a ".." close with a kept
//   segment also passes S_POP (stack read latency). After the last request
//   each result byte passes S_EMIT_RD to read the byte store and S_OUT to
//   present the registered read data.
//   Requests are not taken while a result burst is in flight.
// Reset: synchronous active-low i_rst_n clears control state; the RAMs
//   are not cleared, entries are read only after the current path wrote them.
// Stall: a result holds on the outputs while i_result_ready is low.

module path_dot_segment_simplifier #(
    parameter int MAX_PATH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_path_valid,
    output logic       o_path_ready,
    input  logic [7:0] i_path_byte,
    input  logic       i_path_end,
    output logic       o_result_valid,
    input  logic       i_result_ready,
    output logic [7:0] o_result_byte,
    output logic       o_result_end,
    output logic       o_overflow
);

    localparam int AW  = $clog2(MAX_PATH);
    localparam int PW  = $clog2(MAX_PATH + 1);
    localparam int SD  = MAX_PATH / 2;
    localparam int SAW = $clog2(SD);
    localparam int KW  = $clog2(SD + 1);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_OPEN2   = 6'b000010,
        S_CLOSE   = 6'b000100,
        S_POP     = 6'b001000,
        S_EMIT_RD = 6'b010000,
        S_OUT     = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [PW-1:0]       r_wp, n_wp;
    logic [PW-1:0]       r_cs, n_cs;
    logic [KW-1:0]       r_kept, n_kept;
    pds_pkg::t_seg_class r_class, n_class;
    logic                r_ovf, n_ovf;
    logic                r_last, n_last;
    logic [PW-1:0]       r_k, n_k;
    logic                r_empty, n_empty;
    logic [7:0]          r_byte, n_byte;

    logic                store_we;
    logic [AW-1:0]       store_waddr;
    logic [7:0]          store_wdata;
    logic                store_re;
    logic [7:0]          store_rdata;
    logic                stack_we;
    logic                stack_re;
    logic [SAW-1:0]      stack_raddr;
    logic [PW-1:0]       stack_rdata;

    logic [KW-1:0]       kept_dec;
    logic                open_fits;
    logic                ext_fits;
    logic                name_ok;
    logic [PW:0]         k_next;

    assign kept_dec  = r_kept - KW'(1);
    assign open_fits = ({1'b0, r_wp} + (PW+1)'(2)) <= (PW+1)'(MAX_PATH);
    assign ext_fits  = (r_wp > r_cs) && ({1'b0, r_wp} < (PW+1)'(MAX_PATH));
    assign name_ok   = (({1'b0, r_cs} + (PW+1)'(2)) <= {1'b0, r_wp})
                       && (r_kept < KW'(SD));
    assign k_next    = {1'b0, r_k} + (PW+1)'(1);

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_cs        = r_cs;
        n_kept      = r_kept;
        n_class     = r_class;
        n_ovf       = r_ovf;
        n_last      = r_last;
        n_k         = r_k;
        n_empty     = r_empty;
        n_byte      = r_byte;
        store_we    = 1'b0;
        store_waddr = r_wp[AW-1:0];
        store_wdata = i_path_byte;
        store_re    = 1'b0;
        stack_we    = 1'b0;
        stack_re    = 1'b0;
        stack_raddr = kept_dec[SAW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_path_valid) begin
                    n_last = i_path_end;
                    if (i_path_byte == pds_pkg::CHAR_SLASH) begin
                        n_state = S_CLOSE;
                    end else if (r_class == pds_pkg::CLS_NONE) begin
                        n_cs    = r_wp;
                        n_class = (i_path_byte == pds_pkg::CHAR_DOT) ?
                                  pds_pkg::CLS_DOT : pds_pkg::CLS_NAME;
                        if (open_fits) begin
                            store_we    = 1'b1;
                            store_wdata = pds_pkg::CHAR_SLASH;
                            n_wp        = r_wp + PW'(1);
                            n_byte      = i_path_byte;
                            n_state     = S_OPEN2;
                        end else begin
                            n_ovf   = 1'b1;
                            n_state = i_path_end ? S_CLOSE : S_IDLE;
                        end
                    end else begin
                        n_class = (r_class == pds_pkg::CLS_DOT &&
                                   i_path_byte == pds_pkg::CHAR_DOT) ?
                                  pds_pkg::CLS_DOTDOT : pds_pkg::CLS_NAME;
                        if (ext_fits) begin
                            store_we = 1'b1;
                            n_wp     = r_wp + PW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_state = i_path_end ? S_CLOSE : S_IDLE;
                    end
                end
            end
            S_OPEN2: begin
                store_we    = 1'b1;
                store_wdata = r_byte;
                n_wp        = r_wp + PW'(1);
                n_state     = r_last ? S_CLOSE : S_IDLE;
            end
            S_CLOSE: begin
                n_class = pds_pkg::CLS_NONE;
                n_state = r_last ? S_EMIT_RD : S_IDLE;
                case (r_class)
                    pds_pkg::CLS_DOT: begin
                        n_wp = r_cs;
                    end
                    pds_pkg::CLS_DOTDOT: begin
                        n_wp = r_cs;
                        if (r_kept != '0) begin
                            stack_re = 1'b1;
                            n_kept   = kept_dec;
                            n_state  = S_POP;
                        end
                    end
                    pds_pkg::CLS_NAME: begin
                        if (name_ok) begin
                            stack_we = 1'b1;
                            n_kept   = r_kept + KW'(1);
                        end else begin
                            n_wp = r_cs;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_POP: begin
                n_wp    = stack_rdata;
                n_state = r_last ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD: begin
                if (r_wp == '0) begin
                    n_empty = 1'b1;
                end else begin
                    store_re = 1'b1;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_result_ready) begin
                    if (o_result_end) begin
                        n_wp    = '0;
                        n_cs    = '0;
                        n_kept  = '0;
                        n_class = pds_pkg::CLS_NONE;
                        n_ovf   = 1'b0;
                        n_last  = 1'b0;
                        n_k     = '0;
                        n_empty = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = k_next[PW-1:0];
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_cs    <= '0;
            r_kept  <= '0;
            r_class <= pds_pkg::CLS_NONE;
            r_ovf   <= 1'b0;
            r_last  <= 1'b0;
            r_k     <= '0;
            r_empty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_cs    <= n_cs;
            r_kept  <= n_kept;
            r_class <= n_class;
            r_ovf   <= n_ovf;
            r_last  <= n_last;
            r_k     <= n_k;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    pds_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PATH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (store_wdata),
        .i_re    (store_re),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (store_rdata)
    );

    pds_ram #(
        .WIDTH (PW),
        .DEPTH (SD)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (r_kept[SAW-1:0]),
        .i_wdata (r_cs),
        .i_re    (stack_re),
        .i_raddr (stack_raddr),
        .o_rdata (stack_rdata)
    );

    assign o_path_ready   = (r_state == S_IDLE);
    assign o_result_valid = (r_state == S_OUT);
    assign o_result_byte  = r_empty ? pds_pkg::CHAR_SLASH : store_rdata;
    assign o_result_end   = r_empty || (k_next == {1'b0, r_wp});
    assign o_overflow     = r_ovf;

endmodule

// ===== src/pds_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies; used by the top level for the byte store and the segment stack.

module pds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pds_checker.sv =====
// Port-level checker of the path dot-segment simplifier, bound to the top level.
// Depends on pds_pkg and path_dot_segment_simplifier.

module pds_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_path_valid,
    input logic       o_path_ready,
    input logic       i_path_end,
    input logic       o_result_valid,
    input logic       i_result_ready,
    input logic [7:0] o_result_byte,
    input logic       o_result_end,
    input logic       o_overflow
);

    logic r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (o_result_valid && i_result_ready) begin
            r_first <= o_result_end;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !i_result_ready |=>
            o_result_valid && $stable(o_result_byte) && $stable(o_result_end)
            && $stable(o_overflow))
        else $error("stalled result changed");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_path_ready && o_result_valid))
        else $error("request taken during result burst");

    a_first_slash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && r_first |-> o_result_byte == pds_pkg::CHAR_SLASH)
        else $error("result does not start with slash");

    a_end_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_path_valid && o_path_ready && i_path_end |=> !o_path_ready)
        else $error("request taken right after last byte");

endmodule

bind path_dot_segment_simplifier pds_checker u_pds_checker (.*);

// ===== sim/path_dot_segment_simplifier_tb.sv =====
// Testbench for path_dot_segment_simplifier: a byte-level path canonicalizer checked
// against a predictor on both valid/ready channels. Depends on pds_pkg and the RTL only.
`timescale 1ns / 100ps

module path_dot_segment_simplifier_tb;

    localparam int PATH_CAP       = 64;
    localparam int STACK_CAP      = PATH_CAP / 2;
    localparam int RAND_BYTES     = 290;
    localparam int QUIET_FROM     = 230;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;
    localparam int DIR_ROWS       = 7;
    localparam logic [7:0] ZERO_MARK = "*";

    typedef enum int {
        PM_SHORT,
        PM_LONG,
        PM_NOISE
    } t_path_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       ovf;
    } t_out_char;

    logic       i_clk;
    logic       i_rst_n        = 1'b0;
    logic       i_path_valid   = 1'b0;
    logic [7:0] i_path_byte    = 8'h00;
    logic       i_path_end     = 1'b0;
    logic       i_result_ready = 1'b0;
    logic       o_path_ready;
    logic       o_result_valid;
    logic [7:0] o_result_byte;
    logic       o_result_end;
    logic       o_overflow;

    // predictor state
    logic [7:0] path_text [PATH_CAP];
    logic [6:0] seg_start_stack [STACK_CAP];
    logic [5:0] kept_n     = '0;
    logic [6:0] wr_pos     = '0;
    logic [6:0] open_start = '0;
    pds_pkg::t_seg_class open_cls = pds_pkg::CLS_NONE;
    logic       ovf_seen   = 1'b0;

    t_out_char  step_out[$];
    t_out_char  typed_want[$];
    t_out_char  canon_bytes_q[$];
    logic [7:0] path_buf[$];

    int mismatches   = 0;
    int idle_cycles  = 0;
    int stall_left   = 0;
    int rx_stall_pct = 20;
    bit no_idle      = 1'b0;

    string dir_path [DIR_ROWS] = '{
        "/", ".", "..", "a", "/a/./b/../c", "../../b", "*\377/..."
    };
    // empty entry: check against the predictor
    string dir_want [DIR_ROWS] = '{
        "/", "/", "/", "/a", "/a/c", "/b", ""
    };

    path_dot_segment_simplifier #(
        .MAX_PATH(PATH_CAP)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_path_valid  (i_path_valid),
        .o_path_ready  (o_path_ready),
        .i_path_byte   (i_path_byte),
        .i_path_end    (i_path_end),
        .o_result_valid(o_result_valid),
        .i_result_ready(i_result_ready),
        .o_result_byte (o_result_byte),
        .o_result_end  (o_result_end),
        .o_overflow    (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void close_open_segment();
        case (open_cls)
            pds_pkg::CLS_DOT: begin
                wr_pos = open_start;
            end
            pds_pkg::CLS_DOTDOT: begin
                wr_pos = open_start;
                if (kept_n != 0) begin
                    kept_n = kept_n - 1'b1;
                    wr_pos = seg_start_stack[kept_n];
                end
            end
            pds_pkg::CLS_NAME: begin
                if (wr_pos >= open_start + 2 && kept_n < STACK_CAP) begin
                    seg_start_stack[kept_n] = open_start;
                    kept_n = kept_n + 1'b1;
                end else begin
                    wr_pos = open_start;
                end
            end
            default: begin
            end
        endcase
        open_cls = pds_pkg::CLS_NONE;
    endfunction

    function automatic void simplify_byte(input logic [7:0] b, input logic last);
        int n;
        if (b == pds_pkg::CHAR_SLASH) begin
            close_open_segment();
        end else if (open_cls == pds_pkg::CLS_NONE) begin
            open_start = wr_pos;
            if (wr_pos + 2 <= PATH_CAP) begin
                path_text[wr_pos]     = pds_pkg::CHAR_SLASH;
                path_text[wr_pos + 1] = b;
                wr_pos = wr_pos + 7'd2;
            end else begin
                ovf_seen = 1'b1;
            end
            open_cls = (b == pds_pkg::CHAR_DOT) ? pds_pkg::CLS_DOT : pds_pkg::CLS_NAME;
        end else begin
            open_cls = (open_cls == pds_pkg::CLS_DOT && b == pds_pkg::CHAR_DOT) ?
                       pds_pkg::CLS_DOTDOT : pds_pkg::CLS_NAME;
            if (wr_pos > open_start && wr_pos < PATH_CAP) begin
                path_text[wr_pos] = b;
                wr_pos = wr_pos + 7'd1;
            end else begin
                ovf_seen = 1'b1;
            end
        end
        if (last) begin
            close_open_segment();
            n = wr_pos;
            if (n == 0) begin
                step_out.push_back('{pds_pkg::CHAR_SLASH, 1'b1, ovf_seen});
            end else begin
                for (int k = 0; k < n; k++) begin
                    step_out.push_back('{path_text[k], k == n - 1, ovf_seen});
                end
            end
            kept_n     = '0;
            wr_pos     = '0;
            open_start = '0;
            open_cls   = pds_pkg::CLS_NONE;
            ovf_seen   = 1'b0;
        end
    endfunction

    function automatic void build_path(input t_path_mode mode);
        int goal;
        int nlen;
        int r;
        logic [7:0] c;
        path_buf.delete();
        if (mode == PM_NOISE) begin
            goal = $urandom_range(1, 16);
            for (int j = 0; j < goal; j++) begin
                r = $urandom_range(0, 99);
                c = (r < 35) ? pds_pkg::CHAR_SLASH :
                    (r < 65) ? pds_pkg::CHAR_DOT : 8'($urandom);
                path_buf.push_back(c);
            end
            return;
        end
        goal = (mode == PM_LONG) ? $urandom_range(60, 90) : $urandom_range(1, 20);
        if ($urandom_range(0, 3) != 0) path_buf.push_back(pds_pkg::CHAR_SLASH);
        while (path_buf.size() < goal) begin
            case ($urandom_range(0, 5))
                0: begin
                    path_buf.push_back(pds_pkg::CHAR_DOT);
                end
                1: begin
                    path_buf.push_back(pds_pkg::CHAR_DOT);
                    path_buf.push_back(pds_pkg::CHAR_DOT);
                end
                default: begin
                    nlen = $urandom_range(1, (mode == PM_LONG) ? 12 : 5);
                    for (int j = 0; j < nlen; j++) begin
                        r = $urandom_range(0, 99);
                        c = (r < 60) ? 8'($urandom_range(97, 122)) :
                            (r < 75) ? pds_pkg::CHAR_DOT : 8'($urandom);
                        path_buf.push_back(c);
                    end
                end
            endcase
            for (int j = $urandom_range(0, 2); j >= 0; j--) begin
                path_buf.push_back(pds_pkg::CHAR_SLASH);
            end
        end
        if ($urandom_range(0, 1) == 1) begin
            while (path_buf.size() > 1 && path_buf[$] == pds_pkg::CHAR_SLASH) begin
                void'(path_buf.pop_back());
            end
        end
    endfunction

    task automatic send_request(input logic [7:0] b, input logic last, input bit use_model,
                                input int gap_pct, input bit drain);
        t_out_char r;
        int gap;
        i_path_valid <= 1'b1;
        i_path_byte  <= b;
        i_path_end   <= last;
        do @(posedge i_clk); while (!o_path_ready);
        simplify_byte(b, last);
        while (step_out.size() != 0) begin
            r = step_out.pop_front();
            if (use_model) canon_bytes_q.push_back(r);
        end
        if (!use_model && last) begin
            while (typed_want.size() != 0) canon_bytes_q.push_back(typed_want.pop_front());
        end
        gap = (!no_idle && $urandom_range(1, 100) <= gap_pct) ? $urandom_range(1, 6) : 0;
        if (gap != 0 || drain) begin
            i_path_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            if (drain) begin
                while (canon_bytes_q.size() != 0) @(posedge i_clk);
            end
        end
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", what);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || no_idle || rx_stall_pct == 0) begin
            i_result_ready <= 1'b1;
            stall_left     <= 0;
        end else if (stall_left != 0) begin
            i_result_ready <= 1'b0;
            stall_left     <= stall_left - 1;
        end else if ($urandom_range(1, 100) <= rx_stall_pct) begin
            i_result_ready <= 1'b0;
            stall_left     <= $urandom_range(0, 5);
        end else begin
            i_result_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_char want;
        if (i_rst_n && o_result_valid && i_result_ready) begin
            if (canon_bytes_q.size() == 0) begin
                note_mismatch($sformatf("unexpected result byte %02h end %0b overflow %0b",
                                        o_result_byte, o_result_end, o_overflow));
            end else begin
                want = canon_bytes_q.pop_front();
                if (o_result_byte !== want.ch || o_result_end !== want.last ||
                    o_overflow !== want.ovf) begin
                    note_mismatch($sformatf(
                        "byte %02h/%02h end %0b/%0b overflow %0b/%0b (expected/actual)",
                        want.ch, o_result_byte, want.last, o_result_end,
                        want.ovf, o_overflow));
                end
            end
            if (o_result_end === 1'b1) begin
                case ($urandom_range(0, 2))
                    0:       rx_stall_pct <= 0;
                    1:       rx_stall_pct <= 15;
                    default: rx_stall_pct <= 40;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_path_valid && o_path_ready) || (o_result_valid && i_result_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        string      s;
        string      w;
        logic [7:0] c;
        int         rand_bytes;
        int         gap_pct;
        int         pick;
        bit         drain;
        bit         final_path;
        t_path_mode mode;
        rand_bytes = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            s = dir_path[i];
            w = dir_want[i];
            path_buf.delete();
            typed_want.delete();
            for (int k = 0; k < s.len(); k++) begin
                c = s[k];
                path_buf.push_back((c == ZERO_MARK) ? 8'h00 : c);
            end
            for (int k = 0; k < w.len(); k++) begin
                typed_want.push_back('{8'(w[k]), k == w.len() - 1, 1'b0});
            end
            for (int k = 0; k < path_buf.size(); k++) begin
                send_request(path_buf[k], k == path_buf.size() - 1, w.len() == 0, 30,
                             i == DIR_ROWS - 1 && k == path_buf.size() - 1);
            end
        end

        while (rand_bytes < RAND_BYTES) begin
            pick = $urandom_range(0, 99);
            mode = (pick < 10) ? PM_LONG : (pick < 35) ? PM_NOISE : PM_SHORT;
            build_path(mode);
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 20;
                default: gap_pct = 50;
            endcase
            final_path = rand_bytes + path_buf.size() >= RAND_BYTES;
            drain = final_path ||
                    (rand_bytes < QUIET_FROM && $urandom_range(0, 5) == 0);
            for (int k = 0; k < path_buf.size(); k++) begin
                no_idle = rand_bytes >= QUIET_FROM;
                send_request(path_buf[k], k == path_buf.size() - 1, 1'b1, gap_pct,
                             drain && k == path_buf.size() - 1);
                rand_bytes++;
            end
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && canon_bytes_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/pds_pkg.sv
src/pds_ram.sv
src/path_dot_segment_simplifier.sv
src/pds_checker.sv
sim/path_dot_segment_simplifier_tb.sv
